[hdl/itl_pkg.sv]
// Shared types and constants for the interpolating time table lookup.
// No dependencies; every other file in the project imports this package.
package itl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        at_time;
    logic signed [31:0] point_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic               in_range;
    logic               full_error;
    logic [8:0]         point_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0]        q;
    logic [31:0]        t1;
    logic signed [31:0] v1;
    logic [31:0]        t2;
    logic signed [31:0] v2;
  } interp_ops_t;

endpackage

[hdl/itl_store.sv]
// Point table: time and value memories with one write and one registered read port.
// Depends on itl_pkg for the table depth.
module itl_store
  import itl_pkg::*;
(
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic [31:0]             wr_time,
  input  logic signed [31:0]      wr_value,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic [31:0]             rd_time,
  output logic signed [31:0]      rd_value
);

  logic [31:0]        time_mem [TABLE_DEPTH];
  logic signed [31:0] value_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= wr_time;
      value_mem[wr_addr] <= wr_value;
    end
    rd_time <= time_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

endmodule

[hdl/itl_interp.sv]
// Interpolation unit: two-step multiply, bit-serial 64 by 32 division, saturation.
// Depends on itl_pkg for the operand struct.
module itl_interp
  import itl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  interp_ops_t        ops,
  output logic               done,
  output logic signed [31:0] result
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL1 = 3'd1;
  localparam logic [2:0] A_MUL2 = 3'd2;
  localparam logic [2:0] A_DIV  = 3'd3;
  localparam logic [2:0] A_OUT  = 3'd4;

  logic [2:0]         state;
  logic [31:0]        mq, mv, md;
  logic               neg;
  logic signed [31:0] v1;
  logic [63:0]        dvd;
  logic [31:0]        rem;
  logic [5:0]         cnt;

  logic signed [32:0] dq, dv, dd;
  logic [32:0]        sh;
  logic               ge;
  logic               big;
  logic signed [36:0] sum;

  always_comb begin
    dq = $signed({1'b0, ops.q}) - $signed({1'b0, ops.t1});
    dv = $signed({ops.v2[31], ops.v2}) - $signed({ops.v1[31], ops.v1});
    dd = $signed({1'b0, ops.t2}) - $signed({1'b0, ops.t1});
    sh = {rem, dvd[63]};
    ge = sh >= {1'b0, md};
    big = (|dvd[63:35]) || (dvd[34] && (|dvd[33:0]));
    if (neg) begin
      sum = $signed({{5{v1[31]}}, v1}) - $signed({2'b00, dvd[34:0]});
    end else begin
      sum = $signed({{5{v1[31]}}, v1}) + $signed({2'b00, dvd[34:0]});
    end
    if (big) begin
      result = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (sum > 37'sd2147483647) begin
      result = 32'sh7fff_ffff;
    end else if (sum < -37'sd2147483648) begin
      result = 32'sh8000_0000;
    end else begin
      result = sum[31:0];
    end
  end

  assign done = (state == A_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      case (state)
        A_IDLE: if (start) state <= A_MUL1;
        A_MUL1: state <= A_MUL2;
        A_MUL2: state <= A_DIV;
        A_DIV:  if (cnt == 6'd63) state <= A_OUT;
        A_OUT:  state <= A_IDLE;
        default: state <= A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        if (start) begin
          mq <= dq[32] ? 32'(-dq) : dq[31:0];
          mv <= dv[32] ? 32'(-dv) : dv[31:0];
          md <= dd[32] ? 32'(-dd) : dd[31:0];
          neg <= dq[32] ^ dv[32] ^ dd[32];
          v1 <= ops.v1;
        end
      end
      A_MUL1: dvd <= {16'b0, 48'(mq) * 48'(mv[15:0])};
      A_MUL2: begin
        dvd <= dvd + {48'(mq) * 48'(mv[31:16]), 16'b0};
        rem <= '0;
        cnt <= '0;
      end
      A_DIV: begin
        rem <= ge ? 32'(sh - {1'b0, md}) : sh[31:0];
        dvd <= {dvd[62:0], ge};
        cnt <= cnt + 6'd1;
      end
      default: ;
    endcase
  end

endmodule

[hdl/interpolating_time_table_lookup_top.sv]
// Top level: transaction handshakes, lookup sequencer, table store and interpolation unit.
// Depends on itl_pkg, itl_store and itl_interp.
//
//   channel  direction  handshake             payload
//   req      in         req_valid, req_stall  req_t: kind, at_time, point_value
//   rsp      out        rsp_valid, rsp_stall  rsp_t: out_value, in_range, full_error,
//                                             point_count
//
// Append, clear and unused kinds go straight to the result. A query ends early when it
// falls at the table edges and otherwise takes 2 memory reads per binary search step
// (up to 8 steps for 256 points), 2 reads for the bracketing points and then the
// multiply and the bit-serial divider, all reads sharing the single memory read port.
// Reset empties the table; stored entries are never cleared. A stalled result waits in
// the output register while the next transaction is taken.
module interpolating_time_table_lookup_top
  import itl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_R0   = 4'd1;
  localparam logic [3:0] ST_R1   = 4'd2;
  localparam logic [3:0] ST_S1   = 4'd3;
  localparam logic [3:0] ST_S2   = 4'd4;
  localparam logic [3:0] ST_F1   = 4'd5;
  localparam logic [3:0] ST_F2   = 4'd6;
  localparam logic [3:0] ST_MATH = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]         state;
  logic [CNT_W-1:0]   count;
  logic [31:0]        q;
  logic [CNT_W-1:0]   lo, hi;
  logic [IDX_W-1:0]   mid;
  logic [31:0]        tm, t1;
  logic signed [31:0] v1;
  rsp_t               res;

  logic [IDX_W-1:0]   rd_addr;
  logic [31:0]        rd_time;
  logic signed [31:0] rd_value;
  logic               accept, wr_en;
  logic               hit, cont;
  logic [CNT_W-1:0]   lo_n, hi_n;
  logic [CNT_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid_n, mid_sel, mid_init;
  logic               math_start, math_done;
  logic signed [31:0] math_result;
  interp_ops_t        ops;

  assign accept = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign wr_en = accept && (req.kind == KIND_APPEND) && (count < CNT_W'(TABLE_DEPTH));

  always_comb begin
    hit = (tm >= q) && (rd_time <= q);
    if (tm > q) begin
      lo_n = lo;
      hi_n = CNT_W'(mid) - 1'b1;
    end else begin
      lo_n = CNT_W'(mid) + 1'b1;
      hi_n = hi;
    end
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
    mid_n = mid_sum[IDX_W:1];
    cont = !hit && (lo_n <= hi_n);
    mid_sel = hit ? mid : mid_n;
    mid_init = count[CNT_W-1:1];
    case (state)
      ST_R0: rd_addr = IDX_W'(count - 1'b1);
      ST_R1: rd_addr = mid_init;
      ST_S1: rd_addr = mid - 1'b1;
      ST_S2: begin
        if (cont) begin
          rd_addr = mid_n;
        end else begin
          rd_addr = (mid_sel == '0) ? '0 : mid_sel - 1'b1;
        end
      end
      ST_F1: rd_addr = mid;
      default: rd_addr = '0;
    endcase
    ops = '{q: q, t1: t1, v1: v1, t2: rd_time, v2: rd_value};
    math_start = (state == ST_F2) && (t1 != rd_time);
  end

  itl_store u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (count[IDX_W-1:0]),
    .wr_time  (req.at_time),
    .wr_value (req.point_value),
    .rd_addr  (rd_addr),
    .rd_time  (rd_time),
    .rd_value (rd_value)
  );

  itl_interp u_interp (
    .clk    (clk),
    .rst    (rst),
    .start  (math_start),
    .ops    (ops),
    .done   (math_done),
    .result (math_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && (state != ST_FIN)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            q <= req.at_time;
            res.out_value <= '0;
            res.in_range <= 1'b0;
            res.full_error <= (req.kind == KIND_APPEND) && !wr_en;
            state <= ((req.kind == KIND_QUERY) && (count != '0)) ? ST_R0 : ST_FIN;
            case (req.kind)
              KIND_APPEND: begin
                if (wr_en) begin
                  count <= count + 1'b1;
                  res.point_count <= count + 1'b1;
                end else begin
                  res.point_count <= count;
                end
              end
              KIND_CLEAR: begin
                count <= '0;
                res.point_count <= '0;
              end
              default: res.point_count <= count;
            endcase
          end
        end
        ST_R0: begin
          if (q < rd_time) begin
            state <= ST_FIN;
          end else if (count == CNT_W'(1)) begin
            res.out_value <= rd_value;
            state <= ST_FIN;
          end else begin
            state <= ST_R1;
          end
        end
        ST_R1: begin
          if (q >= rd_time) begin
            res.out_value <= rd_value;
            res.in_range <= 1'b1;
            state <= ST_FIN;
          end else begin
            lo <= CNT_W'(1);
            hi <= count - 1'b1;
            mid <= mid_init;
            state <= ST_S1;
          end
        end
        ST_S1: begin
          tm <= rd_time;
          state <= ST_S2;
        end
        ST_S2: begin
          if (cont) begin
            lo <= lo_n;
            hi <= hi_n;
            mid <= mid_n;
            state <= ST_S1;
          end else begin
            mid <= mid_sel;
            state <= ST_F1;
          end
        end
        ST_F1: begin
          t1 <= rd_time;
          v1 <= rd_value;
          state <= ST_F2;
        end
        ST_F2: begin
          res.in_range <= 1'b1;
          if (t1 == rd_time) begin
            res.out_value <= rd_value;
            state <= ST_FIN;
          end else begin
            state <= ST_MATH;
          end
        end
        ST_MATH: begin
          if (math_done) begin
            res.out_value <= math_result;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp <= res;
            rsp_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
